// ----- src/resp_array_command_parser_top_macros.svh -----
// Assertion macros shared by the request parser modules.
// Define NO_ASSERTIONS to compile the checks away.
`ifndef RESP_ARRAY_COMMAND_PARSER_TOP_MACROS_SVH
`define RESP_ARRAY_COMMAND_PARSER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RAPC_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RAPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RAPC_ASSERT_IMPLY(lbl, ante, cons, msg)
`define RAPC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- src/rapc_pkg.sv -----
// Package for the request array parser: widths, character codes, phase type
// and the per-byte result structure. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rapc_pkg;

    localparam int COUNT_BITS = 32;
    localparam int LEN_BITS   = 32;
    localparam int ACC_W      = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;
    localparam int SUM_W      = ACC_W + 4;
    localparam int IDX_W      = 31;

    localparam logic [SUM_W-1:0] CNT_NEG_MAX = SUM_W'(1) << (COUNT_BITS - 1);
    localparam logic [SUM_W-1:0] LEN_NEG_MAX = SUM_W'(1) << (LEN_BITS - 1);

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [2:0] {
        PH_ARRAY,
        PH_COUNT,
        PH_DOLLAR,
        PH_LEN,
        PH_BODY,
        PH_CR,
        PH_LF
    } t_phase;

    typedef struct packed {
        logic             payload_valid;
        logic [7:0]       payload_byte;
        logic [IDX_W-1:0] arg_index;
        logic             arg_done;
        logic [IDX_W-1:0] arg_length;
        logic             command_done;
        logic [IDX_W-1:0] arg_count;
        logic             parse_error;
    } t_result;

endpackage

`default_nettype wire

// ----- src/rapc_core.sv -----
// Parser state machine: holds the framing state and turns one byte into one
// result per advance. Depends on rapc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "resp_array_command_parser_top_macros.svh"

module rapc_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_advance,
    input  wire logic [7:0]       i_byte,
    output rapc_pkg::t_result     o_result
);
    import rapc_pkg::*;

    t_phase                r_phase, n_phase;
    logic [ACC_W-1:0]      r_acc, n_acc;
    logic                  r_neg, n_neg;
    logic                  r_dseen, n_dseen;
    logic                  r_dclosed, n_dclosed;
    logic                  r_saw_cr, n_saw_cr;
    logic [COUNT_BITS-1:0] r_args_left, n_args_left;
    logic [IDX_W-1:0]      r_cur_arg, n_cur_arg;
    logic [IDX_W-1:0]      r_decl_len, n_decl_len;
    logic [IDX_W-1:0]      r_body_pos, n_body_pos;
    logic                  r_err, n_err;

    logic                  is_digit;
    logic [3:0]            digit;
    logic [SUM_W-1:0]      acc_sum;
    logic [SUM_W-1:0]      acc_lim;
    logic                  nb_err, nb_done;
    logic [ACC_W-1:0]      nb_acc;
    logic                  nb_neg, nb_dseen, nb_dclosed, nb_saw_cr;
    logic [IDX_W-1:0]      cur_arg_inc;
    logic [IDX_W-1:0]      body_pos_inc;
    logic                  last_arg;
    t_result               res;

    assign is_digit     = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign digit        = i_byte[3:0];
    assign cur_arg_inc  = r_cur_arg + IDX_W'(1);
    assign body_pos_inc = r_body_pos + IDX_W'(1);
    assign last_arg     = (r_args_left == COUNT_BITS'(1));

    assign acc_sum = SUM_W'({r_acc, 3'b000}) + SUM_W'({r_acc, 1'b0}) + SUM_W'(digit);
    assign acc_lim = ((r_phase == PH_COUNT) ? CNT_NEG_MAX : LEN_NEG_MAX) - SUM_W'(!r_neg);

    // Decimal field: optional minus, digits, then junk up to CR LF.
    always_comb begin
        nb_err     = 1'b0;
        nb_done    = 1'b0;
        nb_acc     = r_acc;
        nb_neg     = r_neg;
        nb_dseen   = r_dseen;
        nb_dclosed = r_dclosed;
        nb_saw_cr  = r_saw_cr;
        if (!r_dseen) begin
            if (is_digit) begin
                nb_dseen = 1'b1;
                nb_acc   = ACC_W'(digit);
            end else if ((i_byte == CH_MINUS) && !r_neg) begin
                nb_neg = 1'b1;
            end else begin
                nb_err = 1'b1;
            end
        end else if (!r_dclosed && is_digit) begin
            if (acc_sum > acc_lim) begin
                nb_err = 1'b1;
            end else begin
                nb_acc = acc_sum[ACC_W-1:0];
            end
        end else begin
            nb_dclosed = 1'b1;
            if ((i_byte == CH_LF) && r_saw_cr) begin
                nb_done = 1'b1;
            end else begin
                nb_saw_cr = (i_byte == CH_CR);
            end
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_dseen     = r_dseen;
        n_dclosed   = r_dclosed;
        n_saw_cr    = r_saw_cr;
        n_args_left = r_args_left;
        n_cur_arg   = r_cur_arg;
        n_decl_len  = r_decl_len;
        n_body_pos  = r_body_pos;
        n_err       = r_err;
        if (!r_err) begin
            unique case (r_phase)
                PH_ARRAY, PH_DOLLAR: begin
                    if (i_byte == ((r_phase == PH_ARRAY) ? CH_STAR : CH_DOLLAR)) begin
                        n_acc     = '0;
                        n_neg     = 1'b0;
                        n_dseen   = 1'b0;
                        n_dclosed = 1'b0;
                        n_saw_cr  = 1'b0;
                        n_phase   = (r_phase == PH_ARRAY) ? PH_COUNT : PH_LEN;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PH_COUNT: begin
                    n_acc     = nb_acc;
                    n_neg     = nb_neg;
                    n_dseen   = nb_dseen;
                    n_dclosed = nb_dclosed;
                    n_saw_cr  = nb_saw_cr;
                    if (nb_err) begin
                        n_err = 1'b1;
                    end else if (nb_done) begin
                        if (r_neg || (r_acc == '0)) begin
                            n_phase = PH_ARRAY;
                        end else begin
                            n_args_left = r_acc[COUNT_BITS-1:0];
                            n_cur_arg   = '0;
                            n_phase     = PH_DOLLAR;
                        end
                    end
                end
                PH_LEN: begin
                    n_acc     = nb_acc;
                    n_neg     = nb_neg;
                    n_dseen   = nb_dseen;
                    n_dclosed = nb_dclosed;
                    n_saw_cr  = nb_saw_cr;
                    if (nb_err) begin
                        n_err = 1'b1;
                    end else if (nb_done) begin
                        if (r_neg && (r_acc != '0)) begin
                            n_err = 1'b1;
                        end else begin
                            n_decl_len = r_acc[IDX_W-1:0];
                            n_body_pos = '0;
                            n_saw_cr   = 1'b0;
                            n_phase    = (r_acc == '0) ? PH_CR : PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    if ((i_byte == CH_LF) && r_saw_cr) begin
                        n_err = 1'b1;
                    end else begin
                        n_saw_cr   = (i_byte == CH_CR);
                        n_body_pos = body_pos_inc;
                        if (body_pos_inc == r_decl_len) begin
                            n_phase = PH_CR;
                        end
                    end
                end
                PH_CR: begin
                    if (i_byte == CH_CR) begin
                        n_phase = PH_LF;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PH_LF: begin
                    if (i_byte != CH_LF) begin
                        n_err = 1'b1;
                    end else begin
                        n_cur_arg   = cur_arg_inc;
                        n_args_left = r_args_left - COUNT_BITS'(1);
                        n_phase     = last_arg ? PH_ARRAY : PH_DOLLAR;
                    end
                end
                default: begin
                    n_err = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        res = '0;
        if (n_err) begin
            res.parse_error = 1'b1;
        end else begin
            unique case (r_phase)
                PH_COUNT: begin
                    if (nb_done && (r_neg || (r_acc == '0))) begin
                        res.command_done = 1'b1;
                    end
                end
                PH_BODY: begin
                    res.payload_valid = 1'b1;
                    res.payload_byte  = i_byte;
                    res.arg_index     = r_cur_arg;
                end
                PH_LF: begin
                    res.arg_index  = r_cur_arg;
                    res.arg_done   = 1'b1;
                    res.arg_length = r_decl_len;
                    if (last_arg) begin
                        res.command_done = 1'b1;
                        res.arg_count    = cur_arg_inc;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_ARRAY;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_dseen     <= 1'b0;
            r_dclosed   <= 1'b0;
            r_saw_cr    <= 1'b0;
            r_args_left <= '0;
            r_cur_arg   <= '0;
            r_decl_len  <= '0;
            r_body_pos  <= '0;
            r_err       <= 1'b0;
        end else if (i_advance) begin
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_neg       <= n_neg;
            r_dseen     <= n_dseen;
            r_dclosed   <= n_dclosed;
            r_saw_cr    <= n_saw_cr;
            r_args_left <= n_args_left;
            r_cur_arg   <= n_cur_arg;
            r_decl_len  <= n_decl_len;
            r_body_pos  <= n_body_pos;
            r_err       <= n_err;
        end
    end

    `RAPC_ASSERT_NEXT(a_err_sticky, r_err, r_err, "error flag cleared without reset")
    `RAPC_ASSERT_IMPLY(a_body_in_range, r_phase == PH_BODY, r_body_pos < r_decl_len,
        "body position reached the declared length inside the body")
    `RAPC_ASSERT_IMPLY(a_result_kind, 1'b1,
        $onehot0({res.payload_valid, res.arg_done, res.parse_error}),
        "result carries more than one kind of event")
    `RAPC_ASSERT_IMPLY(a_args_nonzero, r_phase == PH_DOLLAR || r_phase == PH_LF,
        r_args_left != '0, "argument countdown ran out inside a command")

endmodule

`default_nettype wire

// ----- src/resp_array_command_parser_top.sv -----
// Top level of the request array parser: input and result registers with
// valid/stall handshakes around rapc_core. Depends on rapc_pkg and rapc_core.
//
// Usage: request bytes enter on i_byte_in with i_in_valid; a transaction is
// taken on a rising edge where i_in_valid is high and o_in_stall is low.
// Every byte yields exactly one result transaction on the output channel,
// presented with o_out_valid and taken when i_out_stall is low.
// A taken byte waits in the input register and is parsed by rapc_core when
// the core advances; its result is then held in the result register.
// Throughput is one byte per cycle unless the receiver stalls; all parsing of
// a byte sits between the input register and the result register.
// While the receiver stalls, the result register holds its payload and the
// input register keeps one more byte; o_in_stall rises only when both are
// full, so no byte is lost or repeated.
// Reset clears both handshake stages and returns the parser to waiting for
// an array marker with the error flag clear. After a framing error every
// result reports o_parse_error until the next reset.
`timescale 1ns / 1ps
`default_nettype none
`include "resp_array_command_parser_top_macros.svh"

module resp_array_command_parser_top (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [7:0]                i_byte_in,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic                           o_payload_valid,
    output logic [7:0]                     o_payload_byte,
    output logic [rapc_pkg::IDX_W-1:0]     o_arg_index,
    output logic                           o_arg_done,
    output logic [rapc_pkg::IDX_W-1:0]     o_arg_length,
    output logic                           o_command_done,
    output logic [rapc_pkg::IDX_W-1:0]     o_arg_count,
    output logic                           o_parse_error
);
    import rapc_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_result    step_res;
    logic       advance;

    assign advance    = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_byte_in;
        end
    end

    rapc_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .o_result  (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_payload_valid = r_out.payload_valid;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_arg_index     = r_out.arg_index;
    assign o_arg_done      = r_out.arg_done;
    assign o_arg_length    = r_out.arg_length;
    assign o_command_done  = r_out.command_done;
    assign o_arg_count     = r_out.arg_count;
    assign o_parse_error   = r_out.parse_error;

    `RAPC_ASSERT_NEXT(a_in_hold, r_in_valid && o_in_stall,
        r_in_valid && $stable(r_in_byte), "held input byte was lost or changed")
    `RAPC_ASSERT_NEXT(a_result_follows, advance, o_out_valid,
        "parsed byte produced no result transaction")
    `RAPC_ASSERT_IMPLY(a_stall_only_full, o_in_stall, r_out_valid && r_in_valid,
        "input stalled while a register stage was free")

endmodule

`default_nettype wire
